// File: hw/rtl/gptlv_pkg.sv
// Package of types and constants for the GPU property TLV parser.
package gptlv_pkg;

   localparam int unsigned KeyBytes   = 4;
   localparam int unsigned ValueBytes = 8;
   localparam int unsigned IdWidth    = 30;
   localparam int unsigned IdxWidth   = 3;

   localparam logic [IdWidth-1:0] IdProduct  = IdWidth'(1);
   localparam logic [IdWidth-1:0] IdVersion  = IdWidth'(2);
   localparam logic [IdWidth-1:0] IdMinorRev = IdWidth'(3);
   localparam logic [IdWidth-1:0] IdMajorRev = IdWidth'(4);
   localparam logic [IdWidth-1:0] IdFreq     = IdWidth'(6);
   localparam logic [IdWidth-1:0] IdMemory   = IdWidth'(12);
   localparam logic [IdWidth-1:0] IdShader   = IdWidth'(25);
   localparam logic [IdWidth-1:0] IdTiler    = IdWidth'(26);
   localparam logic [IdWidth-1:0] IdL2       = IdWidth'(27);
   localparam logic [IdWidth-1:0] IdEngines  = IdWidth'(82);

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_TRUNCATED   = 2'd1,
      STATUS_NO_PRODUCT  = 2'd2
   } status_type;

   // Packed so that the first member sits in the highest bits; the result
   // data bus is assembled field by field in the top level.
   typedef struct packed {
      logic [31:0] exec_engine_count;
      logic [63:0] l2_mask;
      logic [63:0] tiler_mask;
      logic [63:0] shader_mask;
      logic [63:0] memory_bytes;
      logic [31:0] max_freq_khz;
      logic [15:0] rev_major;
      logic [15:0] rev_minor;
      logic [15:0] ver_flags;
      logic [31:0] prod_code;
   } props_type;

   typedef struct packed {
      status_type status;
      props_type  props;
   } result_type;

endpackage

// File: hw/rtl/gpu_property_tlv_parser.sv
// Top level of the byte-serial GPU property TLV parser.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tdata: data_byte; tlast: last_byte
//  rsp      out        rsp_tvalid/rsp_tready  tdata: ten property values; tuser: status
//
// One byte is taken per cycle unless req_tready is low; the parse state updates in
// the cycle the byte is accepted. A blob's result is registered; it waits in the skid
// register while the output register is still full. Two result registers let bytes keep
// flowing while a result waits; req_tready falls only while both hold a result.
// Reset clears the parse state and the captured values and empties both result registers.
module gpu_property_tlv_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [399:0] rsp_tdata,   // prod_code[31:0], ver_flags[15:0],
                                     // rev_minor[15:0], rev_major[15:0],
                                     // max_freq_khz[31:0], memory_bytes[63:0],
                                     // shader_mask[63:0], tiler_mask[63:0],
                                     // l2_mask[63:0], exec_engine_count[31:0]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   logic                                          in_value_ff, in_value_in;
   logic [gptlv_pkg::IdxWidth-1:0]                idx_ff, idx_in;
   logic [gptlv_pkg::KeyBytes-1:0][7:0]           key_ff, key_in;
   logic [gptlv_pkg::ValueBytes-1:0][7:0]         value_ff, value_in;
   logic                                          seen_ff, seen_in;
   gptlv_pkg::props_type                          held_ff, held_in;

   logic                                          out_valid_ff, out_valid_in;
   logic                                          skid_valid_ff, skid_valid_in;
   gptlv_pkg::result_type                         out_ff, out_in;
   gptlv_pkg::result_type                         skid_ff, skid_in;

   logic                                          accept;
   logic                                          push;
   logic                                          out_pop;
   logic [gptlv_pkg::IdxWidth-1:0]                last_idx;
   logic [63:0]                                   value_flat;
   logic [gptlv_pkg::IdWidth-1:0]                 key_id;
   logic                                          value_done;
   logic                                          phase_next;
   logic                                          seen_next;
   gptlv_pkg::props_type                          held_next;
   gptlv_pkg::result_type                         result;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && req_tlast;
   assign out_pop    = out_valid_ff && rsp_tready;

   always_comb begin
      case (key_ff[0][1:0])
         2'd0:    last_idx = 3'd0;
         2'd1:    last_idx = 3'd1;
         2'd2:    last_idx = 3'd3;
         default: last_idx = 3'd7;
      endcase
   end

   assign key_id = {key_ff[3], key_ff[2], key_ff[1], key_ff[0][7:2]};

   // Parse one byte: either a key lane or a value lane is filled.
   always_comb begin
      key_in     = key_ff;
      value_in   = value_ff;
      phase_next = in_value_ff;
      idx_in     = idx_ff;
      seen_next  = seen_ff;
      held_next  = held_ff;
      value_done = 1'b0;
      value_flat = '0;
      if (!in_value_ff) begin
         key_in[idx_ff[1:0]] = req_tdata;
         if (idx_ff[1:0] == 2'd3) begin
            phase_next = 1'b1;
            idx_in     = '0;
            value_in   = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end else begin
         value_in[idx_ff] = req_tdata;
         value_flat       = value_in;
         if (idx_ff >= last_idx) begin
            value_done = 1'b1;
            phase_next = 1'b0;
            idx_in     = '0;
            key_in     = '0;
            value_in   = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (value_done) begin
         case (key_id)
            gptlv_pkg::IdProduct: begin
               held_next.prod_code = value_flat[31:0];
               seen_next           = 1'b1;
            end
            gptlv_pkg::IdVersion:  held_next.ver_flags         = value_flat[15:0];
            gptlv_pkg::IdMinorRev: held_next.rev_minor         = value_flat[15:0];
            gptlv_pkg::IdMajorRev: held_next.rev_major         = value_flat[15:0];
            gptlv_pkg::IdFreq:     held_next.max_freq_khz      = value_flat[31:0];
            gptlv_pkg::IdMemory:   held_next.memory_bytes      = value_flat;
            gptlv_pkg::IdShader:   held_next.shader_mask       = value_flat;
            gptlv_pkg::IdTiler:    held_next.tiler_mask        = value_flat;
            gptlv_pkg::IdL2:       held_next.l2_mask           = value_flat;
            gptlv_pkg::IdEngines:  held_next.exec_engine_count = value_flat[31:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.props = held_next;
      if (phase_next) begin
         result.status = gptlv_pkg::STATUS_TRUNCATED;
      end else if (!seen_next) begin
         result.status = gptlv_pkg::STATUS_NO_PRODUCT;
      end else begin
         result.status = gptlv_pkg::STATUS_OK;
      end
   end

   // A blob's last byte returns all parse state to its reset value.
   always_comb begin
      in_value_in = in_value_ff;
      seen_in     = seen_ff;
      held_in     = held_ff;
      if (accept) begin
         if (req_tlast) begin
            in_value_in = 1'b0;
            seen_in     = 1'b0;
            held_in     = '0;
         end else begin
            in_value_in = phase_next;
            seen_in     = seen_next;
            held_in     = held_next;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff   <= 1'b0;
         idx_ff        <= '0;
         key_ff        <= '0;
         value_ff      <= '0;
         seen_ff       <= 1'b0;
         held_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_value_ff   <= in_value_in;
         seen_ff       <= seen_in;
         held_ff       <= held_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            if (req_tlast) begin
               idx_ff   <= '0;
               key_ff   <= '0;
               value_ff <= '0;
            end else begin
               idx_ff   <= idx_in;
               key_ff   <= key_in;
               value_ff <= value_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {out_ff.props.exec_engine_count,
                        out_ff.props.l2_mask,
                        out_ff.props.tiler_mask,
                        out_ff.props.shader_mask,
                        out_ff.props.memory_bytes,
                        out_ff.props.max_freq_khz,
                        out_ff.props.rev_major,
                        out_ff.props.rev_minor,
                        out_ff.props.ver_flags,
                        out_ff.props.prod_code};

endmodule

// File: sim/gpu_property_tlv_parser_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the result of every property blob and compares it with the output.
module gpu_property_tlv_parser_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tlast,   // last_byte
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [399:0] rsp_tdata,   // prod_code[31:0], ver_flags[15:0],
                                     // rev_minor[15:0], rev_major[15:0],
                                     // max_freq_khz[31:0], memory_bytes[63:0],
                                     // shader_mask[63:0], tiler_mask[63:0],
                                     // l2_mask[63:0], exec_engine_count[31:0]
   input  logic [1:0]   rsp_tuser,   // status[1:0]
   output int           errors,
   output int           pending,
   output int           checked
);

   logic                  in_value;
   logic [2:0]            byte_pos;
   logic [31:0]           key_acc;
   logic [63:0]           value_acc;
   logic                  product_seen;
   gptlv_pkg::props_type  held;
   gptlv_pkg::result_type blob_results[$];

   task automatic report(input string msg);
      if (errors < 40) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      errors++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
      end
   endtask

   task automatic clear_blob();
      in_value     = 1'b0;
      byte_pos     = '0;
      key_acc      = '0;
      value_acc    = '0;
      product_seen = 1'b0;
      held         = '0;
   endtask

   task automatic capture(input logic [gptlv_pkg::IdWidth-1:0] id, input logic [63:0] v);
      case (id)
         gptlv_pkg::IdProduct: begin
            held.prod_code = v[31:0];
            product_seen   = 1'b1;
         end
         gptlv_pkg::IdVersion:  held.ver_flags         = v[15:0];
         gptlv_pkg::IdMinorRev: held.rev_minor         = v[15:0];
         gptlv_pkg::IdMajorRev: held.rev_major         = v[15:0];
         gptlv_pkg::IdFreq:     held.max_freq_khz      = v[31:0];
         gptlv_pkg::IdMemory:   held.memory_bytes      = v;
         gptlv_pkg::IdShader:   held.shader_mask       = v;
         gptlv_pkg::IdTiler:    held.tiler_mask        = v;
         gptlv_pkg::IdL2:       held.l2_mask           = v;
         gptlv_pkg::IdEngines:  held.exec_engine_count = v[31:0];
         default: ;
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b);
      logic [3:0] final_pos;
      final_pos = (4'd1 << key_acc[1:0]) - 4'd1;
      if (!in_value) begin
         key_acc = key_acc | (32'(b) << (8 * byte_pos[1:0]));
         if (byte_pos[1:0] == 2'd3) begin
            in_value  = 1'b1;
            byte_pos  = '0;
            value_acc = '0;
         end else begin
            byte_pos = byte_pos + 3'd1;
         end
      end else begin
         value_acc = value_acc | (64'(b) << (8 * byte_pos));
         if ({1'b0, byte_pos} >= final_pos) begin
            capture(key_acc[31:2], value_acc);
            in_value  = 1'b0;
            byte_pos  = '0;
            key_acc   = '0;
            value_acc = '0;
         end else begin
            byte_pos = byte_pos + 3'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      gptlv_pkg::result_type want;
      gptlv_pkg::result_type got;
      if (reset) begin
         clear_blob();
         blob_results.delete();
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
            if (req_tlast) begin
               if (in_value) begin
                  want.status = gptlv_pkg::STATUS_TRUNCATED;
               end else if (!product_seen) begin
                  want.status = gptlv_pkg::STATUS_NO_PRODUCT;
               end else begin
                  want.status = gptlv_pkg::STATUS_OK;
               end
               want.props = held;
               blob_results.push_back(want);
               clear_blob();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = gptlv_pkg::status_type'(rsp_tuser);
            got.props  = gptlv_pkg::props_type'(rsp_tdata);
            if (blob_results.size() == 0) begin
               report($sformatf("result with status %0d arrived with no blob outstanding",
                                rsp_tuser));
            end else begin
               want = blob_results.pop_front();
               check_field("status", 64'(got.status), 64'(want.status));
               check_field("prod_code", 64'(got.props.prod_code),
                           64'(want.props.prod_code));
               check_field("ver_flags", 64'(got.props.ver_flags),
                           64'(want.props.ver_flags));
               check_field("rev_minor", 64'(got.props.rev_minor),
                           64'(want.props.rev_minor));
               check_field("rev_major", 64'(got.props.rev_major),
                           64'(want.props.rev_major));
               check_field("max_freq_khz", 64'(got.props.max_freq_khz),
                           64'(want.props.max_freq_khz));
               check_field("memory_bytes", got.props.memory_bytes, want.props.memory_bytes);
               check_field("shader_mask", got.props.shader_mask, want.props.shader_mask);
               check_field("tiler_mask", got.props.tiler_mask, want.props.tiler_mask);
               check_field("l2_mask", got.props.l2_mask, want.props.l2_mask);
               check_field("exec_engine_count", 64'(got.props.exec_engine_count),
                           64'(want.props.exec_engine_count));
               checked++;
            end
         end
         pending <= blob_results.size();
      end
   end

endmodule

// File: sim/gpu_property_tlv_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the GPU property TLV parser: clock, reset, blob stimulus and verdict.
module gpu_property_tlv_parser_tb;

   localparam int FillZeros  = 0;
   localparam int FillOnes   = 1;
   localparam int FillRandom = 2;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // data_byte[7:0]
   logic         req_tlast  = 1'b0; // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [399:0] rsp_tdata;         // prod_code .. exec_engine_count, lowest first
   logic [1:0]   rsp_tuser;         // status[1:0]

   int errors;
   int pending;
   int checked;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;
   int blobs_sent     = 0;

   logic [7:0]                    blob_bytes[$];
   logic [gptlv_pkg::IdWidth-1:0] known_ids[10] = '{
      gptlv_pkg::IdProduct, gptlv_pkg::IdVersion, gptlv_pkg::IdMinorRev,
      gptlv_pkg::IdMajorRev, gptlv_pkg::IdFreq, gptlv_pkg::IdMemory, gptlv_pkg::IdShader,
      gptlv_pkg::IdTiler, gptlv_pkg::IdL2, gptlv_pkg::IdEngines};

   gpu_property_tlv_parser dut (.*);

   gpu_property_tlv_parser_checker scoreboard (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("gpu_property_tlv_parser_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_blob();
      foreach (blob_bytes[i]) begin
         send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
      end
      blobs_sent++;
   endtask

   task automatic add_record(input logic [gptlv_pkg::IdWidth-1:0] id,
                             input logic [1:0] len_code, input int value_len, input int fill);
      logic [31:0] key;
      key = {id, len_code};
      for (int i = 0; i < 4; i++) blob_bytes.push_back(key[8*i +: 8]);
      for (int i = 0; i < value_len; i++) begin
         if (fill == FillZeros) begin
            blob_bytes.push_back(8'h00);
         end else if (fill == FillOnes) begin
            blob_bytes.push_back(8'hFF);
         end else begin
            blob_bytes.push_back(8'($urandom));
         end
      end
   endtask

   function automatic logic [gptlv_pkg::IdWidth-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 25) return gptlv_pkg::IdProduct;
      if (r < 80) return known_ids[$urandom_range(9)];
      return gptlv_pkg::IdWidth'($urandom);
   endfunction

   function automatic int pick_fill();
      int r;
      r = $urandom_range(99);
      if (r < 10) return FillZeros;
      if (r < 20) return FillOnes;
      return FillRandom;
   endfunction

   // Mostly well-formed records, ending complete, inside a key or inside a value.
   task automatic make_blob();
      int         n_rec;
      int         ending;
      logic [1:0] len_code;
      blob_bytes.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 16)) blob_bytes.push_back(8'($urandom));
         return;
      end
      n_rec = $urandom_range(0, 5);
      repeat (n_rec) begin
         len_code = 2'($urandom);
         add_record(pick_id(), len_code, 1 << len_code, pick_fill());
      end
      ending = $urandom_range(99);
      if (ending >= 85) begin
         len_code = 2'($urandom);
         add_record(pick_id(), len_code, $urandom_range(0, (1 << len_code) - 1), pick_fill());
      end else if (ending >= 70) begin
         repeat ($urandom_range(1, 3)) blob_bytes.push_back(8'($urandom));
      end
      if (blob_bytes.size() == 0) blob_bytes.push_back(8'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      blob_bytes = '{8'hFF};
      send_blob();
      blob_bytes.delete();
      add_record(gptlv_pkg::IdProduct, 2'd0, 0, FillZeros);
      send_blob();
      blob_bytes.delete();
      add_record(gptlv_pkg::IdProduct, 2'd3, 8, FillOnes);
      send_blob();
      blob_bytes.delete();
      add_record(gptlv_pkg::IdProduct, 2'd1, 2, FillZeros);
      blob_bytes.push_back(8'h00);
      send_blob();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 23 : (phase == 1) ? 59 : 0;
         recv_stall_pct = (phase == 0) ? 59 : (phase == 1) ? 23 : 0;
         while (bytes_sent < 24 + (phase + 1) * 267 || blobs_sent < 4 + (phase + 1) * 12) begin
            make_blob();
            send_blob();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d blobs, directed cases first, then random blobs",
               bytes_sent, blobs_sent);
      $display("under three idling mixes; %0d results compared, %0d mismatches.",
               checked, errors);
      if (errors == 0 && pending == 0) begin
         $display("gpu_property_tlv_parser_tb: done, clean");
      end else begin
         $display("gpu_property_tlv_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
